// File: rtl/rbfc_pkg.sv
// ============================================================================
// rbfc_pkg: shared types and constants for the box face clip core
// Word layouts, fixed-point widths, register map and face codes.
// ============================================================================
package rbfc_pkg;

  // Fixed-point format of every coordinate.
  localparam int FRAC_BITS = 24;
  localparam int CW        = 48;              // coordinate width
  localparam int DW        = CW + 1;          // width of a coordinate difference
  localparam int PW        = CW + 2;          // width of a point or a widened bound
  localparam int HW        = CW / 2;          // half of a magnitude for the products
  localparam int PRW       = HW + FRAC_BITS;  // width of one partial product
  localparam int MW        = CW + FRAC_BITS;  // width of a full product
  localparam int NAX       = 3;

  // Configuration port.
  localparam int EPS_W     = 16;
  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;
  localparam int IDX_W     = ADDR_W - 2;
  localparam logic [IDX_W-1:0] REG_EPSILON = IDX_W'(0);
  localparam logic [EPS_W-1:0] EPS_RESET   = EPS_W'(2);

  // Face codes are axis*2 plus one for the far plane; a miss reports west.
  localparam logic [2:0] FACE_NONE  = 3'd0;
  localparam logic [2:0] FACE_WEST  = 3'd0;
  localparam logic [2:0] FACE_EAST  = 3'd1;
  localparam logic [2:0] FACE_DOWN  = 3'd2;
  localparam logic [2:0] FACE_UP    = 3'd3;
  localparam logic [2:0] FACE_NORTH = 3'd4;
  localparam logic [2:0] FACE_SOUTH = 3'd5;

  localparam logic [CW-1:0] SAT_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] SAT_MIN = {1'b1, {(CW-1){1'b0}}};

  typedef struct packed {
    logic signed [CW-1:0] box_min_x;
    logic signed [CW-1:0] box_min_y;
    logic signed [CW-1:0] box_min_z;
    logic signed [CW-1:0] box_max_x;
    logic signed [CW-1:0] box_max_y;
    logic signed [CW-1:0] box_max_z;
    logic signed [CW-1:0] start_x;
    logic signed [CW-1:0] start_y;
    logic signed [CW-1:0] start_z;
    logic signed [CW-1:0] end_x;
    logic signed [CW-1:0] end_y;
    logic signed [CW-1:0] end_z;
  } in_t;

  typedef struct packed {
    logic                 hit;
    logic [2:0]           face;
    logic signed [CW-1:0] hit_x;
    logic signed [CW-1:0] hit_y;
    logic signed [CW-1:0] hit_z;
  } out_t;

endpackage

// File: rtl/ray_box_face_clip_core.sv
// ============================================================================
// ray_box_face_clip_core: slab clip of one segment against one box
// Finds the face through which a segment first enters an axis-aligned box
// and the entry point, all in signed Q24.24 with saturation.
// ============================================================================
//
//  channel   | signals                                   | direction
//  ----------+-------------------------------------------+----------
//  input     | in_valid, in_ready, in_data (box+segment) | in
//  result    | out_valid, out_ready, out_data            | out
//  config    | psel, penable, pwrite, paddr, pwdata,     | in/out
//            | prdata, pready                            |
//
// One word is accepted per cycle while the output register is empty or taken.
// Most of the pipeline is the restoring divider, one quotient bit per stage.
// All stages advance together whenever the output register is empty or taken,
// so a stall holds every word in place. rst clears only the valid bits and the
// epsilon register, which returns to 2.
module ray_box_face_clip_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  rbfc_pkg::in_t                     in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output rbfc_pkg::out_t                    out_data,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rbfc_pkg::ADDR_W-1:0]       paddr,
  input  logic [rbfc_pkg::DATA_W-1:0]       pwdata,
  output logic [rbfc_pkg::DATA_W-1:0]       prdata,
  output logic                              pready
);

  localparam int F = rbfc_pkg::FRAC_BITS;

  typedef struct packed {
    logic [2:0][rbfc_pkg::DW-1:0] d;
    logic [2:0][rbfc_pkg::DW-1:0] nmin;
    logic [2:0][rbfc_pkg::DW-1:0] nmax;
    logic [2:0][rbfc_pkg::CW-1:0] st;
    logic [2:0][rbfc_pkg::PW-1:0] lo;
    logic [2:0][rbfc_pkg::PW-1:0] hi;
  } a_stage_t;

  typedef struct packed {
    logic                   tst;
    logic                   ok;
    logic [rbfc_pkg::CW-1:0] r;
    logic [F-1:0]           q;
  } lane_t;

  typedef struct packed {
    lane_t [2:0]                  ln;
    logic [2:0][rbfc_pkg::CW-1:0] dm;
    logic [2:0]                   dneg;
    logic [2:0][rbfc_pkg::CW-1:0] st;
    logic [2:0][rbfc_pkg::PW-1:0] lo;
    logic [2:0][rbfc_pkg::PW-1:0] hi;
  } div_stage_t;

  typedef struct packed {
    logic [2:0][F-1:0]                   s;
    logic [2:0]                          pre;
    logic [2:0]                          dneg;
    logic [2:0][rbfc_pkg::CW-1:0]        st;
    logic [2:0][rbfc_pkg::PW-1:0]        lo;
    logic [2:0][rbfc_pkg::PW-1:0]        hi;
    logic [2:0][2:0][rbfc_pkg::PRW-1:0]  ph;
    logic [2:0][2:0][rbfc_pkg::PRW-1:0]  pl;
  } m1_t;

  typedef struct packed {
    logic [2:0][F-1:0]                   s;
    logic [2:0]                          pre;
    logic [2:0]                          dneg;
    logic [2:0][rbfc_pkg::CW-1:0]        st;
    logic [2:0][rbfc_pkg::PW-1:0]        lo;
    logic [2:0][rbfc_pkg::PW-1:0]        hi;
    logic [2:0][2:0][rbfc_pkg::DW-1:0]   v;
  } m2_t;

  typedef struct packed {
    logic [2:0][F-1:0]                   s;
    logic [2:0]                          pre;
    logic [2:0]                          dneg;
    logic [2:0][rbfc_pkg::PW-1:0]        lo;
    logic [2:0][rbfc_pkg::PW-1:0]        hi;
    logic [2:0][2:0][rbfc_pkg::PW-1:0]   pt;
  } m3_t;

  typedef struct packed {
    logic [2:0][F-1:0]                   s;
    logic [2:0]                          cand;
    logic [2:0]                          dneg;
    logic [2:0][2:0][rbfc_pkg::PW-1:0]   pt;
  } m4_t;

  // One restoring step per axis: shift, compare, subtract.
  function automatic div_stage_t div_step(div_stage_t x);
    div_stage_t          y;
    logic [rbfc_pkg::CW:0] t;
    logic                ge;
    y = x;
    for (int a = 0; a < rbfc_pkg::NAX; a++) begin
      t  = {x.ln[a].r, 1'b0};
      ge = t >= {1'b0, x.dm[a]};
      y.ln[a].ok = x.ln[a].ok && (x.ln[a].r < x.dm[a]);
      y.ln[a].r  = ge ? rbfc_pkg::CW'(t - {1'b0, x.dm[a]}) : t[rbfc_pkg::CW-1:0];
      y.ln[a].q  = {x.ln[a].q[F-2:0], ge};
    end
    return y;
  endfunction

  // Clamp a point to the signed coordinate range.
  function automatic logic [rbfc_pkg::CW-1:0] sat_pt(logic [rbfc_pkg::PW-1:0] p);
    logic [rbfc_pkg::CW-1:0] res;
    if (p[rbfc_pkg::PW-1:rbfc_pkg::CW-1] == '0 || p[rbfc_pkg::PW-1:rbfc_pkg::CW-1] == '1) begin
      res = p[rbfc_pkg::CW-1:0];
    end else if (p[rbfc_pkg::PW-1]) begin
      res = rbfc_pkg::SAT_MIN;
    end else begin
      res = rbfc_pkg::SAT_MAX;
    end
    return res;
  endfunction

  logic [rbfc_pkg::EPS_W-1:0] eps;
  logic                       en;

  logic       va;
  a_stage_t   a_q, a_next;
  logic       vdv [0:F];
  div_stage_t dv  [0:F];
  div_stage_t dv0_next;
  logic       vm1, vm2, vm3, vm4;
  m1_t        m1_q, m1_next;
  m2_t        m2_q, m2_next;
  m3_t        m3_q, m3_next;
  m4_t        m4_q, m4_next;
  rbfc_pkg::out_t out_next;

  // Epsilon register on the configuration port.
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      eps <= rbfc_pkg::EPS_RESET;
    end else if (psel && penable && pwrite &&
                 paddr[rbfc_pkg::ADDR_W-1:2] == rbfc_pkg::REG_EPSILON) begin
      eps <= pwdata[rbfc_pkg::EPS_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[rbfc_pkg::ADDR_W-1:2] == rbfc_pkg::REG_EPSILON) begin
      prdata = rbfc_pkg::DATA_W'(eps);
    end
  end

  // The whole pipeline moves when the output register can take a word.
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Stage A: deltas, plane offsets and widened bounds.
  always_comb begin
    logic [2:0][rbfc_pkg::CW-1:0] mn, mx, sv, ev;
    mn = {in_data.box_min_z, in_data.box_min_y, in_data.box_min_x};
    mx = {in_data.box_max_z, in_data.box_max_y, in_data.box_max_x};
    sv = {in_data.start_z, in_data.start_y, in_data.start_x};
    ev = {in_data.end_z, in_data.end_y, in_data.end_x};
    for (int a = 0; a < rbfc_pkg::NAX; a++) begin
      a_next.d[a]    = {ev[a][rbfc_pkg::CW-1], ev[a]} - {sv[a][rbfc_pkg::CW-1], sv[a]};
      a_next.nmin[a] = {mn[a][rbfc_pkg::CW-1], mn[a]} - {sv[a][rbfc_pkg::CW-1], sv[a]};
      a_next.nmax[a] = {mx[a][rbfc_pkg::CW-1], mx[a]} - {sv[a][rbfc_pkg::CW-1], sv[a]};
      a_next.st[a]   = sv[a];
      a_next.lo[a]   = {{2{mn[a][rbfc_pkg::CW-1]}}, mn[a]} - rbfc_pkg::PW'(eps);
      a_next.hi[a]   = {{2{mx[a][rbfc_pkg::CW-1]}}, mx[a]} + rbfc_pkg::PW'(eps);
    end
  end

  // Stage B: direction tests, entry plane and magnitudes for the divider.
  always_comb begin
    logic signed [rbfc_pkg::PW-1:0] eps_s, d_s;
    logic [rbfc_pkg::DW-1:0]        num, num_abs, d_abs;
    logic                           dpos, dng;
    eps_s    = signed'(rbfc_pkg::PW'(eps));
    dv0_next = '0;
    for (int a = 0; a < rbfc_pkg::NAX; a++) begin
      d_s     = signed'({a_q.d[a][rbfc_pkg::DW-1], a_q.d[a]});
      dpos    = d_s > eps_s;
      dng     = d_s < -eps_s;
      num     = dpos ? a_q.nmin[a] : a_q.nmax[a];
      num_abs = num[rbfc_pkg::DW-1] ? (~num + 1'b1) : num;
      d_abs   = a_q.d[a][rbfc_pkg::DW-1] ? (~a_q.d[a] + 1'b1) : a_q.d[a];
      dv0_next.ln[a].tst = dpos || dng;
      dv0_next.ln[a].ok  = (num != '0) && (num[rbfc_pkg::DW-1] == a_q.d[a][rbfc_pkg::DW-1]);
      dv0_next.ln[a].r   = num_abs[rbfc_pkg::CW-1:0];
      dv0_next.ln[a].q   = '0;
      dv0_next.dm[a]     = d_abs[rbfc_pkg::CW-1:0];
      dv0_next.dneg[a]   = a_q.d[a][rbfc_pkg::DW-1];
      dv0_next.st[a]     = a_q.st[a];
      dv0_next.lo[a]     = a_q.lo[a];
      dv0_next.hi[a]     = a_q.hi[a];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va     <= 1'b0;
      vdv[0] <= 1'b0;
    end else if (en) begin
      va     <= in_valid;
      vdv[0] <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_q   <= a_next;
      dv[0] <= dv0_next;
    end
  end

  // Divider: one quotient bit of the scale per stage.
  for (genvar k = 0; k < F; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) begin
        vdv[k+1] <= 1'b0;
      end else if (en) begin
        vdv[k+1] <= vdv[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dv[k+1] <= div_step(dv[k]);
      end
    end
  end

  // M1: partial products of every delta magnitude with every scale.
  always_comb begin
    m1_next.dneg = dv[F].dneg;
    m1_next.st   = dv[F].st;
    m1_next.lo   = dv[F].lo;
    m1_next.hi   = dv[F].hi;
    for (int a = 0; a < rbfc_pkg::NAX; a++) begin
      m1_next.s[a]   = dv[F].ln[a].q;
      m1_next.pre[a] = dv[F].ln[a].tst && dv[F].ln[a].ok && (dv[F].ln[a].q != '0);
      for (int j = 0; j < rbfc_pkg::NAX; j++) begin
        m1_next.ph[a][j] = rbfc_pkg::PRW'(dv[F].dm[j][rbfc_pkg::CW-1:rbfc_pkg::HW])
                           * rbfc_pkg::PRW'(dv[F].ln[a].q);
        m1_next.pl[a][j] = rbfc_pkg::PRW'(dv[F].dm[j][rbfc_pkg::HW-1:0])
                           * rbfc_pkg::PRW'(dv[F].ln[a].q);
      end
    end
  end

  // M2: join the partial products, drop the fraction and apply the sign.
  always_comb begin
    logic [rbfc_pkg::MW-1:0] full;
    logic [rbfc_pkg::DW-1:0] m;
    m2_next.s    = m1_q.s;
    m2_next.pre  = m1_q.pre;
    m2_next.dneg = m1_q.dneg;
    m2_next.st   = m1_q.st;
    m2_next.lo   = m1_q.lo;
    m2_next.hi   = m1_q.hi;
    for (int a = 0; a < rbfc_pkg::NAX; a++) begin
      for (int j = 0; j < rbfc_pkg::NAX; j++) begin
        full = {m1_q.ph[a][j], {rbfc_pkg::HW{1'b0}}} + rbfc_pkg::MW'(m1_q.pl[a][j]);
        m    = {1'b0, full[rbfc_pkg::MW-1:F]};
        m2_next.v[a][j] = m1_q.dneg[j] ? (~m + 1'b1) : m;
      end
    end
  end

  // M3: candidate points for every axis.
  always_comb begin
    m3_next.s    = m2_q.s;
    m3_next.pre  = m2_q.pre;
    m3_next.dneg = m2_q.dneg;
    m3_next.lo   = m2_q.lo;
    m3_next.hi   = m2_q.hi;
    for (int a = 0; a < rbfc_pkg::NAX; a++) begin
      for (int j = 0; j < rbfc_pkg::NAX; j++) begin
        m3_next.pt[a][j] = {{2{m2_q.st[j][rbfc_pkg::CW-1]}}, m2_q.st[j]}
                           + {m2_q.v[a][j][rbfc_pkg::DW-1], m2_q.v[a][j]};
      end
    end
  end

  // M4: a candidate holds when its other two coordinates lie inside the box.
  always_comb begin
    logic in_box;
    m4_next.s    = m3_q.s;
    m4_next.dneg = m3_q.dneg;
    m4_next.pt   = m3_q.pt;
    for (int a = 0; a < rbfc_pkg::NAX; a++) begin
      in_box = 1'b1;
      for (int j = 0; j < rbfc_pkg::NAX; j++) begin
        if (j != a) begin
          in_box = in_box
                   && (signed'(m3_q.lo[j]) < signed'(m3_q.pt[a][j]))
                   && (signed'(m3_q.pt[a][j]) < signed'(m3_q.hi[j]));
        end
      end
      m4_next.cand[a] = m3_q.pre[a] && in_box;
    end
  end

  // Output: nearest candidate in axis order, a tie keeps the earlier axis.
  always_comb begin
    logic [F:0] best;
    logic       found;
    logic [1:0] sel;
    best  = {1'b1, {F{1'b0}}};
    found = 1'b0;
    sel   = 2'd0;
    for (int a = 0; a < rbfc_pkg::NAX; a++) begin
      if (m4_q.cand[a] && ({1'b0, m4_q.s[a]} < best)) begin
        best  = {1'b0, m4_q.s[a]};
        found = 1'b1;
        sel   = 2'(a);
      end
    end
    out_next = '0;
    if (found) begin
      out_next.hit   = 1'b1;
      out_next.face  = {sel, m4_q.dneg[sel]};
      out_next.hit_x = sat_pt(m4_q.pt[sel][0]);
      out_next.hit_y = sat_pt(m4_q.pt[sel][1]);
      out_next.hit_z = sat_pt(m4_q.pt[sel][2]);
    end else begin
      out_next.face  = rbfc_pkg::FACE_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vm1       <= 1'b0;
      vm2       <= 1'b0;
      vm3       <= 1'b0;
      vm4       <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      vm1       <= vdv[F];
      vm2       <= vm1;
      vm3       <= vm2;
      vm4       <= vm3;
      out_valid <= vm4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_q     <= m1_next;
      m2_q     <= m2_next;
      m3_q     <= m3_next;
      m4_q     <= m4_next;
      out_data <= out_next;
    end
  end

endmodule

// File: rtl/rbfc_checker.sv
// ============================================================================
// rbfc_checker: port-level checks for the box face clip core
// Watches the handshakes and the shape of each result word.
// ============================================================================
module rbfc_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input rbfc_pkg::out_t out_data
);

  // A result word that is held back stays unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // The input side is open exactly when the output register can move.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not follow the output register");

  // A miss carries an all-zero word.
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.hit |-> out_data.face == rbfc_pkg::FACE_NONE &&
      out_data.hit_x == '0 && out_data.hit_y == '0 && out_data.hit_z == '0)
    else $error("miss word is not zero");

  // A hit names one of the six faces.
  a_face_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.hit |-> out_data.face <= rbfc_pkg::FACE_SOUTH)
    else $error("face code out of range");

  // Reset empties the pipeline.
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind ray_box_face_clip_core rbfc_checker u_rbfc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// File: tb/sv/tb_top.sv
// ============================================================================
// tb_top: self-checking bench for the box face clip core
// Streams random and directed box/segment words through the core, predicts
// each clip result with a bit-exact slab model, and compares it field by field.
// ============================================================================
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY   = rbfc_pkg::FRAC_BITS + 7;
  localparam int MAX_CYCLE = 2000000;
  localparam logic [rbfc_pkg::ADDR_W-1:0] ADDR_EPS = {rbfc_pkg::REG_EPSILON, 2'b00};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  rbfc_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  rbfc_pkg::out_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [rbfc_pkg::ADDR_W-1:0] paddr = '0;
  logic [rbfc_pkg::DATA_W-1:0] pwdata = '0;
  logic [rbfc_pkg::DATA_W-1:0] prdata;
  logic pready;

  ray_box_face_clip_core dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predictor state: the current tolerance and the queues of pending work.
  logic [63:0] cur_eps = 64'd2;
  rbfc_pkg::in_t pending_words[$];
  rbfc_pkg::out_t expected_clips[$];
  int errors = 0;
  int words_sent = 0;
  int hits_seen = 0;
  int clips_seen = 0;
  longint cycles = 0;
  bit stim_done = 1'b0;
  bit hold_off = 1'b0;

  // Long gaps are rare; most gaps are zero.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  function automatic longint sx48(logic [rbfc_pkg::CW-1:0] v);
    return longint'(signed'(v));
  endfunction

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  // Truncated product of a delta and an unsigned scale, sign applied after.
  function automatic longint scaled(longint d, longint s);
    logic [127:0] p;
    longint m;
    p = 128'(mag(d)) * 128'(s);
    m = longint'(p >> rbfc_pkg::FRAC_BITS);
    return d < 0 ? -m : m;
  endfunction

  function automatic longint clamp48(longint v);
    if (v > 64'sh7FFFFFFFFFFF) return 64'sh7FFFFFFFFFFF;
    if (v < -64'sh800000000000) return -64'sh800000000000;
    return v;
  endfunction

  // Slab test of one entry plane; updates the best scale on acceptance.
  function automatic void try_plane(inout longint best, inout logic [2:0] fc,
      inout bit found, input longint da, db, dc, plane, fa, fb, fcc,
      input longint mnb, mxb, mnc, mxc, input logic [2:0] code);
    longint num, un, ud, s, pb, pc, e;
    e = longint'(cur_eps);
    num = plane - fa;
    if (num == 0 || ((num > 0) != (da > 0))) return;
    un = mag(num);
    ud = mag(da);
    if (un >= ud) return;
    s = longint'((128'(un) << rbfc_pkg::FRAC_BITS) / 128'(ud));
    if (s == 0 || s >= best) return;
    pb = fb + scaled(db, s);
    pc = fcc + scaled(dc, s);
    if (mnb - e < pb && pb < mxb + e && mnc - e < pc && pc < mxc + e) begin
      best = s;
      fc = code;
      found = 1'b1;
    end
  endfunction

  function automatic rbfc_pkg::out_t predict_clip(rbfc_pkg::in_t w);
    longint mnx, mny, mnz, mxx, mxy, mxz, fx, fy, fz, dx, dy, dz, best, e;
    logic [2:0] fc;
    bit found;
    rbfc_pkg::out_t r;
    mnx = sx48(w.box_min_x); mny = sx48(w.box_min_y); mnz = sx48(w.box_min_z);
    mxx = sx48(w.box_max_x); mxy = sx48(w.box_max_y); mxz = sx48(w.box_max_z);
    fx = sx48(w.start_x); fy = sx48(w.start_y); fz = sx48(w.start_z);
    dx = sx48(w.end_x) - fx; dy = sx48(w.end_y) - fy; dz = sx48(w.end_z) - fz;
    e = longint'(cur_eps);
    best = 64'd1 << rbfc_pkg::FRAC_BITS;
    fc = rbfc_pkg::FACE_NONE;
    found = 1'b0;
    if (dx > e) try_plane(best, fc, found, dx, dy, dz, mnx, fx, fy, fz,
                          mny, mxy, mnz, mxz, rbfc_pkg::FACE_WEST);
    else if (dx < -e) try_plane(best, fc, found, dx, dy, dz, mxx, fx, fy, fz,
                                mny, mxy, mnz, mxz, rbfc_pkg::FACE_EAST);
    if (dy > e) try_plane(best, fc, found, dy, dz, dx, mny, fy, fz, fx,
                          mnz, mxz, mnx, mxx, rbfc_pkg::FACE_DOWN);
    else if (dy < -e) try_plane(best, fc, found, dy, dz, dx, mxy, fy, fz, fx,
                                mnz, mxz, mnx, mxx, rbfc_pkg::FACE_UP);
    if (dz > e) try_plane(best, fc, found, dz, dx, dy, mnz, fz, fx, fy,
                          mnx, mxx, mny, mxy, rbfc_pkg::FACE_NORTH);
    else if (dz < -e) try_plane(best, fc, found, dz, dx, dy, mxz, fz, fx, fy,
                                mnx, mxx, mny, mxy, rbfc_pkg::FACE_SOUTH);
    r = '0;
    if (found) begin
      r.hit = 1'b1;
      r.face = fc;
      r.hit_x = rbfc_pkg::CW'(clamp48(fx + scaled(dx, best)));
      r.hit_y = rbfc_pkg::CW'(clamp48(fy + scaled(dy, best)));
      r.hit_z = rbfc_pkg::CW'(clamp48(fz + scaled(dz, best)));
    end
    return r;
  endfunction

  // Random coordinate: mostly small values near the box, some full range.
  function automatic logic [rbfc_pkg::CW-1:0] rand_coord(int spread);
    int r;
    r = $urandom_range(0, 99);
    if (r < 6) return rbfc_pkg::CW'({$urandom, $urandom});
    if (r < 8) return r[0] ? rbfc_pkg::SAT_MAX : rbfc_pkg::SAT_MIN;
    return rbfc_pkg::CW'(longint'($urandom_range(0, 2 * spread)) - longint'(spread));
  endfunction

  // A box, now and then inverted, with a segment that often crosses it.
  function automatic rbfc_pkg::in_t rand_clip();
    rbfc_pkg::in_t w;
    int sp;
    longint lo, hi;
    sp = ($urandom_range(0, 3) == 0) ? 32'h7FFF_FFFF : ($urandom_range(0, 1) ?
         (1 << 26) : 400);
    w = '0;
    for (int a = 0; a < rbfc_pkg::NAX; a++) begin
      lo = sx48(rand_coord(sp));
      hi = lo + longint'($urandom_range(0, sp));
      if ($urandom_range(0, 19) == 0) hi = lo - 1;
      case (a)
        0: begin w.box_min_x = rbfc_pkg::CW'(lo); w.box_max_x = rbfc_pkg::CW'(hi); end
        1: begin w.box_min_y = rbfc_pkg::CW'(lo); w.box_max_y = rbfc_pkg::CW'(hi); end
        default: begin w.box_min_z = rbfc_pkg::CW'(lo); w.box_max_z = rbfc_pkg::CW'(hi); end
      endcase
    end
    w.start_x = rand_coord(sp); w.start_y = rand_coord(sp);
    w.start_z = rand_coord(sp);
    w.end_x = rand_coord(sp); w.end_y = rand_coord(sp); w.end_z = rand_coord(sp);
    if ($urandom_range(0, 9) == 0) w.end_y = w.start_y;
    return w;
  endfunction

  // in_ready as sampled at the last rising edge, so acceptance is unambiguous.
  logic in_ready_s = 1'b0;
  always @(posedge clk) in_ready_s <= in_ready;

  // Driver: presents queued words with random gaps, predicting on accept.
  int send_gap = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready_s) begin
        expected_clips.push_back(predict_clip(in_data));
        words_sent <= words_sent + 1;
      end
      if (in_valid && !in_ready_s) begin
        // Hold the word until it is taken.
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_words.size() > 0 && !hold_off) begin
        in_data <= pending_words.pop_front();
        in_valid <= 1'b1;
        send_gap <= gap_len();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: checks every accepted result against the oldest expectation.
  int recv_gap = 0;
  always @(posedge clk) begin
    rbfc_pkg::out_t exp_r;
    cycles <= cycles + 1;
    if (!rst && out_valid && out_ready) begin
      if (expected_clips.size() == 0) begin
        $error("result word with no expectation: %h", out_data);
        errors <= errors + 1;
      end else begin
        exp_r = expected_clips.pop_front();
        clips_seen <= clips_seen + 1;
        if (exp_r.hit) hits_seen <= hits_seen + 1;
        if (out_data.hit !== exp_r.hit) begin
          $error("hit: expected %0d, actual %0d", exp_r.hit, out_data.hit);
          errors <= errors + 1;
        end
        if (out_data.face !== exp_r.face) begin
          $error("face: expected %0d, actual %0d", exp_r.face, out_data.face);
          errors <= errors + 1;
        end
        if (out_data.hit_x !== exp_r.hit_x) begin
          $error("hit_x: expected %h, actual %h", exp_r.hit_x, out_data.hit_x);
          errors <= errors + 1;
        end
        if (out_data.hit_y !== exp_r.hit_y) begin
          $error("hit_y: expected %h, actual %h", exp_r.hit_y, out_data.hit_y);
          errors <= errors + 1;
        end
        if (out_data.hit_z !== exp_r.hit_z) begin
          $error("hit_z: expected %h, actual %h", exp_r.hit_z, out_data.hit_z);
          errors <= errors + 1;
        end
      end
    end
  end

  // Receiver stalls, changed at the falling edge.
  always @(negedge clk) begin
    if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      out_ready <= 1'b0;
    end else if (out_ready && $urandom_range(0, 3) == 0) begin
      recv_gap <= gap_len();
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Waits until every queued word has been accepted and every result checked.
  task automatic drain();
    while (pending_words.size() > 0 || in_valid || expected_clips.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // Register write: setup cycle, then access cycle.
  task automatic write_eps(logic [rbfc_pkg::EPS_W-1:0] v);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= ADDR_EPS; pwdata <= rbfc_pkg::DATA_W'(v);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    cur_eps = 64'(v);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  function automatic rbfc_pkg::in_t mk(longint mn, mx, sx, sy, sz, ex, ey, ez);
    rbfc_pkg::in_t w;
    w.box_min_x = rbfc_pkg::CW'(mn); w.box_min_y = rbfc_pkg::CW'(mn);
    w.box_min_z = rbfc_pkg::CW'(mn);
    w.box_max_x = rbfc_pkg::CW'(mx); w.box_max_y = rbfc_pkg::CW'(mx);
    w.box_max_z = rbfc_pkg::CW'(mx);
    w.start_x = rbfc_pkg::CW'(sx); w.start_y = rbfc_pkg::CW'(sy);
    w.start_z = rbfc_pkg::CW'(sz);
    w.end_x = rbfc_pkg::CW'(ex); w.end_y = rbfc_pkg::CW'(ey); w.end_z = rbfc_pkg::CW'(ez);
    return w;
  endfunction

  initial begin
    logic [rbfc_pkg::EPS_W-1:0] eps_set[4];
    longint one;
    longint smin, smax;
    rbfc_pkg::in_t w;
    one = 64'd1 << rbfc_pkg::FRAC_BITS;
    smin = sx48(rbfc_pkg::SAT_MIN);
    smax = sx48(rbfc_pkg::SAT_MAX);
    eps_set = '{16'd0, 16'hFFFF, 16'd2, 16'd37};
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed words: each face, misses, ties, extremes, inverted boxes.
    pending_words.push_back(mk(-one, one, -3*one, 0, 0, 3*one, 0, 0));
    pending_words.push_back(mk(-one, one, 3*one, 0, 0, -3*one, 0, 0));
    pending_words.push_back(mk(-one, one, 0, -3*one, 0, 0, 3*one, 0));
    pending_words.push_back(mk(-one, one, 0, 3*one, 0, 0, -3*one, 0));
    pending_words.push_back(mk(-one, one, 0, 0, -3*one, 0, 0, 3*one));
    pending_words.push_back(mk(-one, one, 0, 0, 3*one, 0, 0, -3*one));
    pending_words.push_back(mk(-one, one, -3*one, -3*one, -3*one, 3*one, 3*one, 3*one));
    pending_words.push_back(mk(-one, one, 0, 0, 0, 2*one, 0, 0));
    pending_words.push_back(mk(-one, one, -3*one, 5*one, 0, 3*one, 5*one, 0));
    pending_words.push_back(mk(-one, one, -one, 0, 0, one, 0, 0));
    pending_words.push_back(mk(-one, one, -3*one, 0, 0, -2*one, 0, 0));
    pending_words.push_back(mk(-one, one, 0, 0, 0, 0, 0, 0));
    pending_words.push_back(mk(-one, one, -3*one, 0, 0, -3*one + 1, 0, 0));
    pending_words.push_back(mk(one, -one, -3*one, 0, 0, 3*one, 0, 0));
    pending_words.push_back(mk(-one, one, -2*one, one, 0, 2*one, one, 0));
    pending_words.push_back(mk(smin, smax, smin, 0, 0, smax, 0, 0));
    pending_words.push_back(mk(smin, smax, smax, smax, smin, smin, smin, smax));
    pending_words.push_back(mk(-1, 1, -(64'd1 << 46), 0, 0, 64'd1 << 46, 0, 0));
    pending_words.push_back(mk(-one, one, -one - 1, 0, 0, one + 1, 0, 0));
    w = '1;
    pending_words.push_back(w);
    w = '0;
    pending_words.push_back(w);
    drain();

    // Random phases, one per tolerance setting, with a full pause midway.
    for (int ph = 0; ph < 4; ph++) begin
      write_eps(eps_set[ph]);
      for (int i = 0; i < 210; i++) pending_words.push_back(rand_clip());
      while (pending_words.size() > 0) @(posedge clk);
      hold_off = 1'b1;
      while (in_valid || expected_clips.size() > 0) @(posedge clk);
      hold_off = 1'b0;
      for (int i = 0; i < 210; i++) pending_words.push_back(rand_clip());
      drain();
    end
    stim_done = 1'b1;
  end

  // End of run, or timeout.
  always @(posedge clk) begin
    if (stim_done) begin
      $display("Sent %0d words and checked %0d clip results (%0d hits).",
               words_sent, clips_seen, hits_seen);
      $display("Covered directed faces and extremes plus four tolerance settings.");
      if (errors == 0) begin
        $display("RESULT: OK");
      end else begin
        $display("RESULT: ERROR");
      end
      $finish;
    end else if (cycles > MAX_CYCLE) begin
      $display("Timeout after %0d cycles.", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

endmodule

// File: sim.f
rtl/rbfc_pkg.sv
rtl/ray_box_face_clip_core.sv
rtl/rbfc_checker.sv
tb/sv/tb_top.sv
